@@ rtl/core/rdct_pkg.sv @@
// Shared constants, codes and a helper function of the reload down-counter timer.
package rdct_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned STATUS_W    = 8;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned PSC_W       = 3;
  localparam int unsigned COUNT_BITS_DEF = 12;

  localparam logic [DATA_W-1:0] ZERO_VEC_RST  = 16'o0304;
  localparam logic [DATA_W-1:0] EVENT_VEC_RST = 16'o0310;
  localparam logic [DATA_W-1:0] READ_UNMAPPED = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_EVENT = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd3;

  localparam logic [IDX_W-1:0] REG_STATUS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_RLD_BUF = 2'd1;
  localparam logic [IDX_W-1:0] REG_COUNT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_VEC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_VEC = 1'b1;

  localparam int unsigned ST_RUN  = 0;
  localparam int unsigned ST_OVF  = 3;
  localparam int unsigned ST_EVIE = 4;
  localparam int unsigned ST_EV   = 5;
  localparam int unsigned ST_ZIE  = 6;
  localparam int unsigned ST_ZERO = 7;

  localparam logic [STATUS_W-1:0] ST_HW_MASK = 8'o0250;

  typedef logic [STATUS_W-1:0] status_t;

  function automatic logic [PSC_W:0] prescale_limit(input logic [1:0] sel);
    logic [PSC_W:0] lim;
    case (sel)
      2'd0:    lim = 4'd1;
      2'd1:    lim = 4'd2;
      2'd2:    lim = 4'd4;
      default: lim = 4'd8;
    endcase
    return lim;
  endfunction

endpackage

@@ rtl/core/reload_down_counter_timer_core.sv @@
// Top level of the reload down-counter timer: state update and result register.
//
// The block takes one operation per input beat: a base tick, an event edge,
// a register read or a register write. Each accepted beat yields exactly one
// result beat with the read data, the interrupt vector offered after the
// operation and the run bit. The timer state is updated at the edge that
// accepts the input beat and the result is captured in the output register
// at the same edge. One beat is taken per cycle while the receiver keeps up.
// The output register is the only storage between the channels; a new input
// beat is accepted whenever the output register is empty or is being emptied
// in the same cycle. When the receiver stalls, the result is held and input
// stalls after one beat. The configuration channel writes the two interrupt
// vectors and is always ready; it is meant to be used while the block is
// idle. Synchronous reset clears the status, counter, reload and prescaler,
// loads the default vectors and empties the output register.
module reload_down_counter_timer_core
  import rdct_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IDX_W-1:0]     in_reg_index,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic                 in_event_enable,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_read_data,
  output logic [DATA_W-1:0]    out_irq_vector,
  output logic                 out_running,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  status_t               status_r, status_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [PSC_W-1:0]      psc_r, psc_nxt;
  logic [DATA_W-1:0]     zvec_r, evec_r;
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_rdata_r, out_irq_r;
  logic                  out_run_r;

  logic                  in_acc;
  logic [DATA_W-1:0]     rdata_nxt;
  logic [DATA_W-1:0]     irq_nxt;
  logic [PSC_W:0]        psc_inc;
  logic [COUNT_BITS-1:0] count_dec;

  assign in_ready  = ~out_valid_r | out_ready;
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  assign psc_inc   = {1'b0, psc_r} + {{PSC_W{1'b0}}, 1'b1};
  assign count_dec = count_r - {{(COUNT_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    status_nxt = status_r;
    reload_nxt = reload_r;
    count_nxt  = count_r;
    psc_nxt    = psc_r;
    rdata_nxt  = '0;
    case (in_operation)
      OP_TICK: begin
        if (status_r[ST_RUN] && !status_r[ST_EV]) begin
          if (psc_inc >= prescale_limit(status_r[2:1])) begin
            psc_nxt = '0;
            if (count_dec == '0) begin
              if (status_r[ST_ZERO]) begin
                status_nxt[ST_OVF] = 1'b1;
              end
              status_nxt[ST_ZERO] = 1'b1;
              count_nxt = reload_r;
            end else begin
              count_nxt = count_dec;
            end
          end else begin
            psc_nxt = psc_inc[PSC_W-1:0];
          end
        end
      end
      OP_EVENT: begin
        if (in_event_enable) begin
          status_nxt[ST_EV] = 1'b1;
        end
      end
      OP_READ: begin
        case (in_reg_index)
          REG_STATUS: begin
            rdata_nxt = DATA_W'(status_r);
            status_nxt[ST_OVF] = 1'b0;
          end
          REG_COUNT: begin
            rdata_nxt = DATA_W'(count_r);
            if (status_r[ST_ZERO] || status_r[ST_EV]) begin
              status_nxt[ST_ZERO] = 1'b0;
              status_nxt[ST_EV]   = 1'b0;
              count_nxt = reload_r;
            end
          end
          default: begin
            rdata_nxt = READ_UNMAPPED;
          end
        endcase
      end
      default: begin
        case (in_reg_index)
          REG_STATUS: begin
            if (in_write_data[ST_RUN] && !status_r[ST_RUN]) begin
              count_nxt = reload_r;
            end
            status_nxt = (status_r & ST_HW_MASK) | (in_write_data[STATUS_W-1:0] & ~ST_HW_MASK);
            psc_nxt = '0;
          end
          REG_RLD_BUF: begin
            reload_nxt = in_write_data[COUNT_BITS-1:0];
            if (!status_r[ST_RUN]) begin
              count_nxt = in_write_data[COUNT_BITS-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_comb begin
    if (status_nxt[ST_ZERO] && status_nxt[ST_ZIE]) begin
      irq_nxt = zvec_r;
    end else if (status_nxt[ST_EV] && status_nxt[ST_EVIE]) begin
      irq_nxt = evec_r;
    end else begin
      irq_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      reload_r    <= '0;
      count_r     <= '0;
      psc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        status_r    <= status_nxt;
        reload_r    <= reload_nxt;
        count_r     <= count_nxt;
        psc_r       <= psc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zvec_r <= ZERO_VEC_RST;
      evec_r <= EVENT_VEC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ZERO_VEC:  zvec_r <= cfg_data;
        CFG_EVENT_VEC: evec_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_rdata_r <= rdata_nxt;
      out_irq_r   <= irq_nxt;
      out_run_r   <= status_nxt[ST_RUN];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_rdata_r;
  assign out_irq_vector = out_irq_r;
  assign out_running    = out_run_r;

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted input did not produce a result beat");

  a_status_read_clears_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == OP_READ && in_reg_index == REG_STATUS |=> !status_r[ST_OVF])
    else $error("status read left overflow set");

  a_event_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == OP_TICK && status_r[ST_EV] |=> $stable(count_r) && $stable(psc_r))
    else $error("tick advanced the counter while an event was pending");

  a_status_write_restarts_psc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == OP_WRITE && in_reg_index == REG_STATUS |=> psc_r == '0)
    else $error("status write did not restart the prescaler");

  a_no_accept_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(count_r) && $stable(status_r) && $stable(reload_r))
    else $error("timer state changed without an accepted beat");

endmodule

@@ bench/timer_result_checker.sv @@
// Checker for the reload down-counter timer: tracks state, predicts each result beat, compares.
module timer_result_checker
  import rdct_pkg::*;
#(
  parameter int unsigned CNT_W = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IDX_W-1:0]     in_reg_index,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic                 in_event_enable,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DATA_W-1:0]    out_read_data,
  input  logic [DATA_W-1:0]    out_irq_vector,
  input  logic                 out_running,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   results_outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] irq_vector;
    logic              running;
  } bus_result_t;

  logic [DATA_W-1:0] zero_vec;
  logic [DATA_W-1:0] event_vec;
  status_t           timer_status;
  logic [CNT_W-1:0]  reload_val;
  logic [CNT_W-1:0]  count_val;
  logic [PSC_W:0]    prescale_cnt;
  bus_result_t       awaited_results[$];
  int                errors = 0;
  int                result_beats = 0;

  assign mismatch_count = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic apply_timer_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] wdata, input logic ev_en,
                                output bus_result_t res);
    logic [DATA_W-1:0] rd;
    rd = '0;
    case (op)
      OP_TICK: begin
        if (timer_status[ST_RUN] && !timer_status[ST_EV]) begin
          prescale_cnt = prescale_cnt + 1'b1;
          if (int'(prescale_cnt) >= (1 << timer_status[2:1])) begin
            prescale_cnt = '0;
            count_val = count_val - 1'b1;
            if (count_val == '0) begin
              if (timer_status[ST_ZERO]) timer_status[ST_OVF] = 1'b1;
              timer_status[ST_ZERO] = 1'b1;
              count_val = reload_val;
            end
          end
        end
      end
      OP_EVENT: begin
        if (ev_en) timer_status[ST_EV] = 1'b1;
      end
      OP_READ: begin
        if (idx == REG_STATUS) begin
          rd = DATA_W'(timer_status);
          timer_status[ST_OVF] = 1'b0;
        end else if (idx == REG_COUNT) begin
          rd = DATA_W'(count_val);
          if (timer_status[ST_ZERO] || timer_status[ST_EV]) begin
            timer_status[ST_ZERO] = 1'b0;
            timer_status[ST_EV] = 1'b0;
            count_val = reload_val;
          end
        end else begin
          rd = READ_UNMAPPED;
        end
      end
      OP_WRITE: begin
        if (idx == REG_STATUS) begin
          if (wdata[ST_RUN] && !timer_status[ST_RUN]) count_val = reload_val;
          timer_status = (timer_status & ST_HW_MASK) | (wdata[STATUS_W-1:0] & ~ST_HW_MASK);
          prescale_cnt = '0;
        end else if (idx == REG_RLD_BUF) begin
          reload_val = wdata[CNT_W-1:0];
          if (!timer_status[ST_RUN]) count_val = reload_val;
        end
      end
    endcase
    res.read_data = rd;
    if (timer_status[ST_ZERO] && timer_status[ST_ZIE]) res.irq_vector = zero_vec;
    else if (timer_status[ST_EV] && timer_status[ST_EVIE]) res.irq_vector = event_vec;
    else res.irq_vector = '0;
    res.running = timer_status[ST_RUN];
  endtask

  always @(posedge clk) begin
    bus_result_t want;
    if (!rst_n) begin
      zero_vec = ZERO_VEC_RST;
      event_vec = EVENT_VEC_RST;
      timer_status = '0;
      reload_val = '0;
      count_val = '0;
      prescale_cnt = '0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_beats++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with none outstanding",
                                    result_beats));
        end else begin
          want = awaited_results.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch($sformatf("beat %0d read_data %h, predicted %h",
                                      result_beats, out_read_data, want.read_data));
          if (out_irq_vector !== want.irq_vector)
            report_mismatch($sformatf("beat %0d irq_vector %h, predicted %h",
                                      result_beats, out_irq_vector, want.irq_vector));
          if (out_running !== want.running)
            report_mismatch($sformatf("beat %0d running %b, predicted %b",
                                      result_beats, out_running, want.running));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ZERO_VEC) zero_vec = cfg_data;
        else event_vec = cfg_data;
      end
      if (in_valid && in_ready) begin
        apply_timer_op(in_operation, in_reg_index, in_write_data, in_event_enable, want);
        awaited_results.insert(awaited_results.size(), want);
      end
    end
    results_outstanding <= awaited_results.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the reload down-counter timer: clock, reset, stimulus and verdict.
module tb_top;
  import rdct_pkg::*;

  localparam int ITEMS_PER_PHASE = 475;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = OP_TICK;
  logic [IDX_W-1:0]     in_reg_index = REG_STATUS;
  logic [DATA_W-1:0]    in_write_data = '0;
  logic                 in_event_enable = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    out_read_data;
  logic [DATA_W-1:0]    out_irq_vector;
  logic                 out_running;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ZERO_VEC;
  logic [DATA_W-1:0]    cfg_data = '0;
  int                   mismatch_count;
  int                   results_outstanding;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   cycles = 0;
  int                   ops_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  reload_down_counter_timer_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_reg_index    (in_reg_index),
    .in_write_data   (in_write_data),
    .in_event_enable (in_event_enable),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_irq_vector  (out_irq_vector),
    .out_running     (out_running),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  timer_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_reg_index        (in_reg_index),
    .in_write_data       (in_write_data),
    .in_event_enable     (in_event_enable),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_irq_vector      (out_irq_vector),
    .out_running         (out_running),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("reload_down_counter_timer_core verification failed");
      $finish;
    end
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [DATA_W-1:0] wdata, input logic ev_en);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_reg_index <= idx;
    in_write_data <= wdata;
    in_event_enable <= ev_en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  task automatic set_vectors(input logic [DATA_W-1:0] zero_vec, input logic [DATA_W-1:0] event_vec);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ZERO_VEC;
    cfg_data <= zero_vec;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_EVENT_VEC;
    cfg_data <= event_vec;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_op();
    int                pick;
    int                sub;
    logic [DATA_W-1:0] d;
    logic [IDX_W-1:0]  idx;
    pick = $urandom_range(99);
    sub = $urandom_range(9);
    d = DATA_W'($urandom);
    if (pick < 12) begin
      // A well-formed run: stop, load a short reload value, start, tick, read back.
      d[ST_RUN] = 1'b0;
      send_op(OP_WRITE, REG_STATUS, d, 1'($urandom));
      d = DATA_W'($urandom);
      d[11:0] = 12'($urandom_range(9));
      send_op(OP_WRITE, REG_RLD_BUF, d, 1'($urandom));
      d = DATA_W'($urandom);
      d[ST_RUN] = 1'b1;
      send_op(OP_WRITE, REG_STATUS, d, 1'($urandom));
      repeat ($urandom_range(1, 30)) send_op(OP_TICK, IDX_W'($urandom), DATA_W'($urandom),
                                               1'($urandom));
      send_op(OP_READ, REG_STATUS, DATA_W'($urandom), 1'($urandom));
      send_op(OP_READ, REG_COUNT, DATA_W'($urandom), 1'($urandom));
    end else if (pick < 55) begin
      send_op(OP_TICK, IDX_W'($urandom), d, 1'($urandom));
    end else if (pick < 63) begin
      send_op(OP_EVENT, IDX_W'($urandom), d, ($urandom_range(3) != 0));
    end else if (pick < 82) begin
      if (sub < 4) idx = REG_STATUS;
      else if (sub < 8) idx = REG_COUNT;
      else if (sub == 8) idx = REG_RLD_BUF;
      else idx = REG_UNMAPPED;
      send_op(OP_READ, idx, d, 1'($urandom));
    end else begin
      if (sub < 4) begin
        idx = REG_STATUS;
        d[ST_RUN] = ($urandom_range(4) != 0);
      end else if (sub < 8) begin
        idx = REG_RLD_BUF;
        if (sub != 7) d[11:0] = 12'($urandom_range(9));
      end else if (sub == 8) begin
        idx = REG_COUNT;
      end else begin
        idx = REG_UNMAPPED;
      end
      send_op(OP_WRITE, idx, d, 1'($urandom));
    end
  endtask

  initial begin
    logic [DATA_W-1:0] zero_set[6];
    logic [DATA_W-1:0] event_set[6];
    zero_set = '{16'h0000, DATA_W'($urandom), 16'hFFFF, DATA_W'($urandom), DATA_W'($urandom),
                 ZERO_VEC_RST};
    event_set = '{16'hFFFF, DATA_W'($urandom), 16'h0000, DATA_W'($urandom), DATA_W'($urandom),
                  EVENT_VEC_RST};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct <= 23;
    recv_idle_pct <= 69;
    @(posedge clk);

    send_op(OP_READ, REG_STATUS, 16'h0000, 1'b0);
    send_op(OP_READ, REG_RLD_BUF, 16'h0000, 1'b0);
    send_op(OP_READ, REG_UNMAPPED, 16'hFFFF, 1'b1);
    send_op(OP_WRITE, REG_UNMAPPED, 16'hFFFF, 1'b1);
    send_op(OP_WRITE, REG_COUNT, 16'hFFFF, 1'b0);
    send_op(OP_WRITE, REG_RLD_BUF, 16'h0000, 1'b0);
    send_op(OP_WRITE, REG_STATUS, 16'h0051, 1'b0);
    send_op(OP_TICK, REG_STATUS, 16'h0000, 1'b0);
    send_op(OP_READ, REG_COUNT, 16'h0000, 1'b0);
    send_op(OP_WRITE, REG_STATUS, 16'h0000, 1'b0);
    send_op(OP_WRITE, REG_RLD_BUF, 16'hF002, 1'b0);
    send_op(OP_WRITE, REG_STATUS, 16'h0051, 1'b0);
    repeat (4) send_op(OP_TICK, REG_STATUS, 16'h0000, 1'b0);
    send_op(OP_READ, REG_STATUS, 16'h0000, 1'b0);
    send_op(OP_READ, REG_COUNT, 16'h0000, 1'b0);
    send_op(OP_EVENT, REG_STATUS, 16'h0000, 1'b0);
    send_op(OP_EVENT, REG_STATUS, 16'h0000, 1'b1);
    send_op(OP_TICK, REG_STATUS, 16'h0000, 1'b1);
    send_op(OP_READ, REG_COUNT, 16'h0000, 1'b0);
    send_op(OP_WRITE, REG_STATUS, 16'hFFFF, 1'b1);
    send_op(OP_WRITE, REG_RLD_BUF, 16'hFFFF, 1'b1);
    send_op(OP_TICK, REG_STATUS, 16'h0000, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      for (int half = 0; half < 2; half++) begin
        wait_idle();
        set_vectors(zero_set[2 * phase + half], event_set[2 * phase + half]);
        if (half == 0) begin
          send_idle_pct <= (phase == 0) ? 23 : (phase == 1) ? 69 : 0;
          recv_idle_pct <= (phase == 0) ? 69 : (phase == 1) ? 23 : 0;
        end
        while (ops_sent < 25 + phase * ITEMS_PER_PHASE + (half + 1) * ITEMS_PER_PHASE / 2)
          send_random_op();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("reload_down_counter_timer_core verification clean");
    end else begin
      $display("reload_down_counter_timer_core verification failed");
    end
    $finish;
  end

endmodule
